// File: hw/rtl/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types, constants and the arctangent table of the lead-aim controller.
// ----------------------------------------------------------------------------
package tla_pkg;

   localparam int CordicIters = 16;

   localparam logic signed [20:0] PI_Q16      = 21'sd205887;
   localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [36:0] CORDIC_K    = 37'sd652032874;
   localparam logic signed [35:0] VEL_LIMIT   = 36'sd4294901760;

   // register indexes
   localparam logic [2:0] REG_TURRET_X  = 3'd0;
   localparam logic [2:0] REG_TURRET_Y  = 3'd1;
   localparam logic [2:0] REG_SPEED     = 3'd2;
   localparam logic [2:0] REG_STEP      = 3'd3;
   localparam logic [2:0] REG_MAX_ANGLE = 3'd4;
   localparam logic [2:0] REG_MIN_ANGLE = 3'd5;
   localparam logic [2:0] REG_MAX_RANGE = 3'd6;
   localparam logic [2:0] REG_COOLDOWN  = 3'd7;

   typedef enum logic {
      MODE_VECTOR = 1'b0,
      MODE_ROTATE = 1'b1
   } cordic_mode_type;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'b00000000000000001,
      ST_SQX   = 17'b00000000000000010,
      ST_SQY   = 17'b00000000000000100,
      ST_SQSUM = 17'b00000000000001000,
      ST_SQRT  = 17'b00000000000010000,
      ST_LMUL  = 17'b00000000000100000,
      ST_LDIVS = 17'b00000000001000000,
      ST_LDIV  = 17'b00000000010000000,
      ST_ATANS = 17'b00000000100000000,
      ST_ATAN  = 17'b00000001000000000,
      ST_SLEW  = 17'b00000010000000000,
      ST_TRIGS = 17'b00000100000000000,
      ST_TRIG  = 17'b00001000000000000,
      ST_VELX  = 17'b00010000000000000,
      ST_VELY  = 17'b00100000000000000,
      ST_VELE  = 17'b01000000000000000,
      ST_OUT   = 17'b10000000000000000
   } state_type;

   function automatic logic signed [20:0] atan_lut(input logic [3:0] idx);
      logic signed [20:0] v;
      case (idx)
         4'd0:    v = 21'sd51472;
         4'd1:    v = 21'sd30386;
         4'd2:    v = 21'sd16055;
         4'd3:    v = 21'sd8150;
         4'd4:    v = 21'sd4091;
         4'd5:    v = 21'sd2047;
         4'd6:    v = 21'sd1024;
         4'd7:    v = 21'sd512;
         4'd8:    v = 21'sd256;
         4'd9:    v = 21'sd128;
         4'd10:   v = 21'sd64;
         4'd11:   v = 21'sd32;
         4'd12:   v = 21'sd16;
         4'd13:   v = 21'sd8;
         4'd14:   v = 21'sd4;
         4'd15:   v = 21'sd2;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/tla_sqrt.sv
// ----------------------------------------------------------------------------
// tla_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tla_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   logic [63:0] v_ff, v_in;
   logic [33:0] r_ff, r_in;
   logic [31:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [35:0] trial, tval;

   always_comb begin
      v_in = v_ff; r_in = r_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, v_ff[63:62]};
      tval  = {2'b00, q_ff, 2'b01};
      if (start) begin
         v_in = radicand; r_in = '0; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[61:0], 2'b00};
         if (trial >= tval) begin
            r_in = 34'(trial - tval);
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial[33:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; r_ff <= r_in; q_ff <= q_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign root = q_ff;
   assign done = done_ff;
endmodule

// File: hw/rtl/tla_div.sv
// ----------------------------------------------------------------------------
// tla_div
// Restoring divider: 47-bit dividend by 16-bit divisor, low 32 quotient bits
// one per cycle, with a flag for quotients of 2^32 or more.
// ----------------------------------------------------------------------------
module tla_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [46:0] dividend,
   input  logic [15:0] divisor,
   output logic [31:0] quot,
   output logic        big,
   output logic        done
);
   logic [15:0] d_ff, d_in, rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        big_ff, big_in, busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      d_in = d_ff; rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff; big_in = big_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[31]};
      if (start) begin
         d_in   = divisor;
         big_in = ({1'b0, dividend[46:32]} >= divisor);
         rem_in = big_in ? 16'd0 : {1'b0, dividend[46:32]};
         q_in   = dividend[31:0];
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = 16'(trial - {1'b0, d_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in; rem_ff <= rem_in; q_ff <= q_in; cnt_ff <= cnt_in; big_ff <= big_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign big  = big_ff;
   assign done = done_ff;
endmodule

// File: hw/rtl/tla_cordic.sv
// ----------------------------------------------------------------------------
// tla_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module tla_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tla_pkg::cordic_mode_type mode,
   input  logic signed [36:0]       x0,
   input  logic signed [36:0]       y0,
   input  logic signed [20:0]       z0,
   output logic signed [36:0]       x,
   output logic signed [36:0]       y,
   output logic signed [20:0]       z,
   output logic                     done
);
   logic signed [36:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [20:0] z_ff, z_in, at;
   logic [3:0]         cnt_ff, cnt_in;
   tla_pkg::cordic_mode_type mode_ff, mode_in;
   logic busy_ff, busy_in, done_ff, done_in, up;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; cnt_in = cnt_ff; mode_in = mode_ff;
      busy_in = busy_ff; done_in = 1'b0;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = tla_pkg::atan_lut(cnt_ff);
      up = (mode_ff == tla_pkg::MODE_VECTOR) ? (y_ff > 0) : (z_ff >= 0);
      if (start) begin
         x_in = x0; y_in = y0; z_in = z0; mode_in = mode; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mode_ff == tla_pkg::MODE_VECTOR) begin
            if (up) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end
         end else begin
            if (up) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; cnt_ff <= cnt_in; mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
   assign done = done_ff;
endmodule

// File: hw/rtl/target_lead_aim_controller_core.sv
// ----------------------------------------------------------------------------
// target_lead_aim_controller_core
// Turret controller that leads a moving target and fires when on aim.
// ----------------------------------------------------------------------------
// A position item (req_type 0) stores the target and its change since the
// last position, and gives no result. A tick item (req_type 1) runs a
// sequencer over a shared 34x34 multiplier, a one-bit-per-cycle square root,
// a one-bit-per-cycle divider (once per axis) and a 16-step CORDIC (for
// atan2 unless the aim point lies on the x axis, again for cos/sin on a
// launch). req_stall is high for the whole of a tick. The result item sits
// in an output register, so the next item may be accepted while it waits.
// ----------------------------------------------------------------------------
module target_lead_aim_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [18:0] rsp_aim_angle,
   output logic               rsp_launch,
   output logic signed [32:0] rsp_launch_vel_x,
   output logic signed [32:0] rsp_launch_vel_y,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   // configuration
   logic signed [31:0] turret_x_ff, turret_y_ff;
   logic [15:0]        speed_cfg_ff;
   logic [17:0]        step_ff;
   logic signed [18:0] max_angle_ff, min_angle_ff;
   logic [31:0]        max_range_ff;
   logic [7:0]         cool_ticks_ff;

   // state
   logic signed [31:0] pos_x_ff, pos_y_ff, dlt_x_ff, dlt_y_ff;
   logic signed [18:0] cur_ff, cur_in;
   logic [8:0]         cool_ff, cool_in;

   // work registers
   tla_pkg::state_type state_ff, state_in;
   logic signed [32:0] dx_ff, dy_ff;
   logic [15:0]        speed_ff;
   logic [63:0]        sum_ff;
   logic               sat_ff;
   logic [31:0]        dist_ff;
   logic signed [67:0] prod_ff;
   logic               axis_ff;
   logic signed [33:0] aimx_ff, aimy_ff;
   logic signed [18:0] des_ff, des_in;
   logic               neg_ff, fire_ff;
   logic signed [32:0] vx_ff, vy_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [18:0] o_angle_ff;
   logic               o_launch_ff;
   logic signed [32:0] o_vx_ff, o_vy_ff;

   logic req_acc, out_free;
   assign req_acc  = req_valid && !req_stall;
   assign req_stall = (state_ff != tla_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // shared multiplier, operands picked by the sequencer state
   // ------------------------------------------------------------------------
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [31:0]        ax, ay, mag;
   logic signed [36:0] cx, cy;
   logic signed [36:0] vsrc;

   assign ax  = dx_ff[32] ? 32'(-dx_ff) : dx_ff[31:0];
   assign ay  = dy_ff[32] ? 32'(-dy_ff) : dy_ff[31:0];
   assign mag = axis_ff ? (dlt_y_ff[31] ? 32'(-33'(dlt_y_ff)) : dlt_y_ff[31:0])
                        : (dlt_x_ff[31] ? 32'(-33'(dlt_x_ff)) : dlt_x_ff[31:0]);

   always_comb begin
      mul_a = '0;
      mul_b = {18'd0, speed_ff};
      vsrc  = neg_ff ? -cx : cx;
      case (state_ff)
         tla_pkg::ST_SQX: begin
            mul_a = {2'b00, ax}; mul_b = {2'b00, ax};
         end
         tla_pkg::ST_SQY: begin
            mul_a = {2'b00, ay}; mul_b = {2'b00, ay};
         end
         tla_pkg::ST_LMUL: begin
            mul_a = {2'b00, mag}; mul_b = {2'b00, dist_ff};
         end
         tla_pkg::ST_VELX: begin
            mul_a = 34'(vsrc);
         end
         tla_pkg::ST_VELY: begin
            // -sin: the pi shift already negated it
            vsrc  = neg_ff ? cy : -cy;
            mul_a = 34'(vsrc);
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // ------------------------------------------------------------------------
   // iterative units
   // ------------------------------------------------------------------------
   logic        sq_start, sq_done, dv_start, dv_done, dv_big, cd_start, cd_done;
   logic [64:0] sq_sum;
   logic [31:0] sq_root, dv_quot;
   tla_pkg::cordic_mode_type cd_mode;
   logic signed [36:0] cd_x0, cd_y0;
   logic signed [20:0] cd_z0, cz;

   assign sq_sum   = {1'b0, sum_ff} + {1'b0, prod_ff[63:0]};
   assign sq_start = (state_ff == tla_pkg::ST_SQSUM);
   assign dv_start = (state_ff == tla_pkg::ST_LDIVS);

   tla_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_sum[63:0]),
      .root(sq_root), .done(sq_done)
   );

   tla_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(prod_ff[62:16]),
      .divisor(speed_ff), .quot(dv_quot), .big(dv_big), .done(dv_done)
   );

   // CORDIC setup: a negative x is turned by pi first; a wide angle is
   // shifted by pi with the outputs negated afterwards
   logic signed [20:0] cur_w;
   logic               trig_neg;
   always_comb begin
      cd_start = 1'b0;
      cd_mode  = tla_pkg::MODE_VECTOR;
      cd_x0    = 37'(aimx_ff);
      cd_y0    = 37'(aimy_ff);
      cd_z0    = '0;
      cur_w    = 21'(cur_ff);
      trig_neg = 1'b0;
      if (state_ff == tla_pkg::ST_ATANS) begin
         cd_start = (aimy_ff != 0);
         if (aimx_ff < 0) begin
            cd_x0 = -37'(aimx_ff);
            cd_y0 = -37'(aimy_ff);
            cd_z0 = (aimy_ff > 0) ? tla_pkg::PI_Q16 : -tla_pkg::PI_Q16;
         end
      end else if (state_ff == tla_pkg::ST_TRIGS) begin
         cd_start = 1'b1;
         cd_mode  = tla_pkg::MODE_ROTATE;
         cd_x0    = tla_pkg::CORDIC_K;
         cd_y0    = '0;
         cd_z0    = cur_w;
         if (cur_w > tla_pkg::HALF_PI_Q16) begin
            cd_z0 = cur_w - tla_pkg::PI_Q16; trig_neg = 1'b1;
         end else if (cur_w < -tla_pkg::HALF_PI_Q16) begin
            cd_z0 = cur_w + tla_pkg::PI_Q16; trig_neg = 1'b1;
         end
      end
   end

   tla_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cd_start), .mode(cd_mode),
      .x0(cd_x0), .y0(cd_y0), .z0(cd_z0), .x(cx), .y(cy), .z(cz), .done(cd_done)
   );

   // ------------------------------------------------------------------------
   // lead offset from the quotient, saturated, and the aim point
   // ------------------------------------------------------------------------
   logic               dsign;
   logic signed [31:0] lead;
   logic signed [33:0] aim_new;
   always_comb begin
      dsign = axis_ff ? dlt_y_ff[31] : dlt_x_ff[31];
      if (!dsign) begin
         lead = (dv_big || dv_quot[31]) ? 32'sh7FFFFFFF : $signed(dv_quot);
      end else begin
         lead = (dv_big || (dv_quot > 32'h80000000)) ? 32'sh80000000
                                                      : $signed(32'(-dv_quot));
      end
      aim_new = (axis_ff ? 34'(dy_ff) : 34'(dx_ff)) + 34'(lead);
   end

   // ------------------------------------------------------------------------
   // desired angle, slew and launch decision
   // ------------------------------------------------------------------------
   logic signed [20:0] nz, d21, c21, lim, nxt, mx21, mn21;
   logic               fire;
   always_comb begin
      nz = -cz;
      if (nz > tla_pkg::PI_Q16)       des_in = 19'(tla_pkg::PI_Q16);
      else if (nz < -tla_pkg::PI_Q16) des_in = 19'(-tla_pkg::PI_Q16);
      else                            des_in = 19'(nz);

      d21  = 21'(des_ff);
      c21  = 21'(cur_ff);
      mx21 = 21'(max_angle_ff);
      mn21 = 21'(min_angle_ff);
      lim  = d21;
      nxt  = c21;
      cur_in = cur_ff;
      if (c21 < d21) begin
         lim = (d21 < mx21) ? d21 : mx21;
         nxt = c21 + $signed({3'b000, step_ff});
         cur_in = 19'((nxt < lim) ? nxt : lim);
      end else if (c21 > d21) begin
         lim = (d21 > mn21) ? d21 : mn21;
         nxt = c21 - $signed({3'b000, step_ff});
         cur_in = 19'((nxt > lim) ? nxt : lim);
      end
      fire = (cur_in == des_ff) && (cool_ff == 9'd0) && (dist_ff <= max_range_ff);
      // a launch reloads to ticks, and each later tick takes one off until zero
      if (fire)               cool_in = {1'b0, cool_ticks_ff};
      else if (cool_ff != 0)  cool_in = cool_ff - 9'd1;
      else                    cool_in = cool_ff;
   end

   // velocity: Q1.30 times speed, round half up by 14, clamp
   function automatic logic signed [32:0] vel_of(input logic signed [67:0] p);
      logic signed [49:0] r;
      logic signed [35:0] v;
      r = p[49:0] + 50'sd8192;
      v = 36'(r >>> 14);
      if (v > tla_pkg::VEL_LIMIT)       v = tla_pkg::VEL_LIMIT;
      else if (v < -tla_pkg::VEL_LIMIT) v = -tla_pkg::VEL_LIMIT;
      return 33'(v);
   endfunction

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tla_pkg::ST_IDLE:  if (req_acc && req_type) state_in = tla_pkg::ST_SQX;
         tla_pkg::ST_SQX:   state_in = tla_pkg::ST_SQY;
         tla_pkg::ST_SQY:   state_in = tla_pkg::ST_SQSUM;
         tla_pkg::ST_SQSUM: state_in = tla_pkg::ST_SQRT;
         tla_pkg::ST_SQRT:  if (sq_done) state_in = tla_pkg::ST_LMUL;
         tla_pkg::ST_LMUL:  state_in = tla_pkg::ST_LDIVS;
         tla_pkg::ST_LDIVS: state_in = tla_pkg::ST_LDIV;
         tla_pkg::ST_LDIV: begin
            if (dv_done) state_in = axis_ff ? tla_pkg::ST_ATANS : tla_pkg::ST_LMUL;
         end
         tla_pkg::ST_ATANS: state_in = (aimy_ff == 0) ? tla_pkg::ST_SLEW : tla_pkg::ST_ATAN;
         tla_pkg::ST_ATAN:  if (cd_done) state_in = tla_pkg::ST_SLEW;
         tla_pkg::ST_SLEW:  state_in = fire ? tla_pkg::ST_TRIGS : tla_pkg::ST_OUT;
         tla_pkg::ST_TRIGS: state_in = tla_pkg::ST_TRIG;
         tla_pkg::ST_TRIG:  if (cd_done) state_in = tla_pkg::ST_VELX;
         tla_pkg::ST_VELX:  state_in = tla_pkg::ST_VELY;
         tla_pkg::ST_VELY:  state_in = tla_pkg::ST_VELE;
         tla_pkg::ST_VELE:  state_in = tla_pkg::ST_OUT;
         tla_pkg::ST_OUT:   if (out_free) state_in = tla_pkg::ST_IDLE;
         default:           state_in = tla_pkg::ST_IDLE;
      endcase
   end

   // work registers (payload, no reset)
   logic signed [32:0] ndx, ndy;
   assign ndx = 33'(req_target_x) - 33'(pos_x_ff);
   assign ndy = 33'(req_target_y) - 33'(pos_y_ff);

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         tla_pkg::ST_IDLE: begin
            dx_ff    <= 33'(pos_x_ff) - 33'(turret_x_ff);
            dy_ff    <= 33'(pos_y_ff) - 33'(turret_y_ff);
            speed_ff <= (speed_cfg_ff == 16'd0) ? 16'd1 : speed_cfg_ff;
            axis_ff  <= 1'b0;
         end
         tla_pkg::ST_SQY:   sum_ff <= prod_ff[63:0];
         tla_pkg::ST_SQSUM: sat_ff <= sq_sum[64];
         tla_pkg::ST_SQRT:  if (sq_done) dist_ff <= sat_ff ? 32'hFFFFFFFF : sq_root;
         tla_pkg::ST_LDIV: begin
            if (dv_done) begin
               if (axis_ff) aimy_ff <= aim_new;
               else         aimx_ff <= aim_new;
               axis_ff <= 1'b1;
            end
         end
         tla_pkg::ST_ATANS: begin
            // on the x axis: the desired angle is 0, or -pi for negative x
            if (aimy_ff == 0) des_ff <= (aimx_ff < 0) ? 19'(-tla_pkg::PI_Q16) : 19'sd0;
         end
         tla_pkg::ST_ATAN:  if (cd_done) des_ff <= des_in;
         tla_pkg::ST_SLEW: begin
            fire_ff <= fire;
            vx_ff   <= '0;
            vy_ff   <= '0;
         end
         tla_pkg::ST_TRIGS: neg_ff <= trig_neg;
         tla_pkg::ST_VELY:  vx_ff <= vel_of(prod_ff);
         tla_pkg::ST_VELE:  vy_ff <= vel_of(prod_ff);
         default: ;
      endcase
      if (state_ff == tla_pkg::ST_OUT && out_free) begin
         o_angle_ff  <= cur_ff;
         o_launch_ff <= fire_ff;
         o_vx_ff     <= vx_ff;
         o_vy_ff     <= vy_ff;
      end
   end

   // control, configuration and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tla_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         turret_x_ff   <= '0;
         turret_y_ff   <= '0;
         speed_cfg_ff  <= 16'd1;
         step_ff       <= 18'd3277;
         max_angle_ff  <= 19'sd205887;
         min_angle_ff  <= -19'sd205887;
         max_range_ff  <= 32'hFFFFFFFF;
         cool_ticks_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         dlt_x_ff      <= '0;
         dlt_y_ff      <= '0;
         cur_ff        <= '0;
         cool_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tla_pkg::ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)         rsp_valid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               tla_pkg::REG_TURRET_X:  turret_x_ff   <= csr_wdata;
               tla_pkg::REG_TURRET_Y:  turret_y_ff   <= csr_wdata;
               tla_pkg::REG_SPEED:     speed_cfg_ff  <= csr_wdata[15:0];
               tla_pkg::REG_STEP:      step_ff       <= csr_wdata[17:0];
               tla_pkg::REG_MAX_ANGLE: max_angle_ff  <= csr_wdata[18:0];
               tla_pkg::REG_MIN_ANGLE: min_angle_ff  <= csr_wdata[18:0];
               tla_pkg::REG_MAX_RANGE: max_range_ff  <= csr_wdata;
               tla_pkg::REG_COOLDOWN:  cool_ticks_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end

         // position item: delta saturates to 32 bits
         if (req_acc && !req_type) begin
            if (ndx > 33'sh07FFFFFFF)       dlt_x_ff <= 32'sh7FFFFFFF;
            else if (ndx < -33'sh080000000) dlt_x_ff <= 32'sh80000000;
            else                            dlt_x_ff <= 32'(ndx);
            if (ndy > 33'sh07FFFFFFF)       dlt_y_ff <= 32'sh7FFFFFFF;
            else if (ndy < -33'sh080000000) dlt_y_ff <= 32'sh80000000;
            else                            dlt_y_ff <= 32'(ndy);
            pos_x_ff <= req_target_x;
            pos_y_ff <= req_target_y;
         end

         if (state_ff == tla_pkg::ST_SLEW) begin
            cur_ff  <= cur_in;
            cool_ff <= cool_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_aim_angle    = o_angle_ff;
   assign rsp_launch       = o_launch_ff;
   assign rsp_launch_vel_x = o_vx_ff;
   assign rsp_launch_vel_y = o_vy_ff;
endmodule

// File: hw/rtl/tla_checker.sv
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks of the lead-aim controller, bound to the top level.
// ----------------------------------------------------------------------------
module tla_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_type,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [18:0] rsp_aim_angle,
   input logic               rsp_launch,
   input logic signed [32:0] rsp_launch_vel_x,
   input logic signed [32:0] rsp_launch_vel_y
);
   // a stalled result stays valid and keeps its angle and launch flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_aim_angle) && $stable(rsp_launch))
      else $error("stalled result changed");

   // no launch means zero velocity
   a_no_launch_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_launch |-> rsp_launch_vel_x == 0 && rsp_launch_vel_y == 0)
      else $error("velocity without launch");

   // a tick item makes the block busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type |=> req_stall)
      else $error("tick item did not start work");

   // a position item leaves the block ready
   a_pos_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_type |=> !req_stall)
      else $error("position item blocked the input");

   // aim never leaves plus or minus pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_aim_angle <= 19'sd205887 && rsp_aim_angle >= -19'sd205887)
      else $error("aim angle out of range");
endmodule

bind target_lead_aim_controller_core tla_checker u_tla_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_aim_angle(rsp_aim_angle), .rsp_launch(rsp_launch),
   .rsp_launch_vel_x(rsp_launch_vel_x), .rsp_launch_vel_y(rsp_launch_vel_y)
);
